/* rtl/nfpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nfpa_pkg;

    localparam int FIRST_W = 12;
    localparam int COUNT_W = 13;
    localparam int REQ_W   = 25;
    localparam int START_W = 12;
    localparam int ADDR_W  = 64;
    localparam int FREE_W  = 13;
    localparam int TOTAL_W = 13;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 96;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'd1;

    localparam logic [FREE_W-1:0]  COUNT_MAX     = 13'h1FFF;
    localparam logic [TOTAL_W-1:0] TOTAL_DEFAULT = 13'd4096;

    localparam logic MODE_FREE  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]   request_bytes;
        logic [COUNT_W-1:0] page_count;
        logic [FIRST_W-1:0] first_page;
        logic               mode;
    } nfpa_item_t;

    typedef struct packed {
        logic [FREE_W-1:0]  free_pages;
        logic [ADDR_W-1:0]  address;
        logic [START_W-1:0] start_page;
        logic               ok;
    } nfpa_result_t;

endpackage

`default_nettype wire

/* rtl/nfpa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module nfpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/nfpa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module nfpa_ctrl #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire nfpa_pkg::nfpa_item_t        item,
    input  wire logic [$clog2(MAX_PAGES):0]  total_used,
    input  wire logic [nfpa_pkg::ADDR_W-1:0] base_address,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output nfpa_pkg::nfpa_result_t           res
);

    localparam int PAGE_W = $clog2(MAX_PAGES);
    localparam int TOT_W  = PAGE_W + 1;
    localparam int PBL    = $clog2(PAGE_BYTES);
    localparam int NEED_W = nfpa_pkg::REQ_W + 1 - PBL;
    localparam int PTR_W  = (TOT_W > nfpa_pkg::COUNT_W) ? TOT_W : nfpa_pkg::COUNT_W + 1;
    localparam int RM_W   = (NEED_W > nfpa_pkg::COUNT_W) ? NEED_W : nfpa_pkg::COUNT_W;
    localparam int SUM_W  = nfpa_pkg::REQ_W + 1;

    localparam logic [PTR_W-1:0] PTR_MAX  = PTR_W'(MAX_PAGES);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_PAGES - 1);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_FREE   = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_TAKE   = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    logic [PTR_W-1:0]            ptr_reg, ptr_next;
    logic [RM_W-1:0]             rem_reg, rem_next;
    logic [NEED_W-1:0]           need_reg, need_next;
    logic [PAGE_W-1:0]           scan_pos_reg, scan_pos_next;
    logic [PAGE_W-1:0]           run_start_reg, run_start_next;
    logic [NEED_W-1:0]           run_len_reg, run_len_next;
    logic                        in_run_reg, in_run_next;
    logic                        wrapped_reg, wrapped_next;
    logic [PAGE_W-1:0]           cursor_reg, cursor_next;
    logic [nfpa_pkg::FREE_W-1:0] fc_reg, fc_next;
    logic                        ok_reg, ok_next;
    logic                        mode_reg, mode_next;
    logic [PAGE_W-1:0]           start_reg, start_next;

    logic              ram_we;
    logic [PAGE_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic [PAGE_W-1:0] ram_raddr;
    logic              ram_rdata;

    logic [SUM_W-1:0]  req_sum;
    logic [NEED_W-1:0] need_calc;
    logic [PAGE_W-1:0] pos0;
    logic [TOT_W-1:0]  pos_inc;
    logic              at_end;
    logic [PAGE_W-1:0] nxt_pos;
    logic              run_hit;
    logic [RM_W-1:0]   fc_ext;
    logic [RM_W-1:0]   need_ext;

    nfpa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_PAGES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_sum   = {1'b0, item.request_bytes} + SUM_W'(PAGE_BYTES - 1);
    assign need_calc = req_sum[SUM_W-1:PBL];
    assign pos0      = ({1'b0, cursor_reg} >= total_used) ? '0 : cursor_reg;
    assign pos_inc   = {1'b0, scan_pos_reg} + TOT_W'(1);
    assign at_end    = pos_inc >= total_used;
    assign nxt_pos   = at_end ? '0 : pos_inc[PAGE_W-1:0];
    assign fc_ext    = RM_W'(fc_reg);
    assign need_ext  = RM_W'(need_reg);

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        rem_next       = rem_reg;
        need_next      = need_reg;
        scan_pos_next  = scan_pos_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        in_run_next    = in_run_reg;
        wrapped_next   = wrapped_reg;
        cursor_next    = cursor_reg;
        fc_next        = fc_reg;
        ok_next        = ok_reg;
        mode_next      = mode_reg;
        start_next     = start_reg;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg[PAGE_W-1:0];
        ram_wdata      = 1'b1;
        ram_raddr      = nxt_pos;
        run_hit        = 1'b0;
        item_ready     = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (ptr_reg == PTR_LAST)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + PTR_W'(1);
                end
            end

            ST_IDLE:
            begin
                item_ready = 1'b1;
                ram_raddr  = pos0;
                if (item_valid)
                begin
                    mode_next  = item.mode;
                    start_next = '0;
                    ok_next    = 1'b1;
                    if (item.mode == nfpa_pkg::MODE_FREE)
                    begin
                        ptr_next   = PTR_W'(item.first_page);
                        rem_next   = RM_W'(item.page_count);
                        state_next = ST_FREE;
                    end
                    else if (need_calc == '0)
                    begin
                        ok_next     = 1'b0;
                        cursor_next = '0;
                        state_next  = ST_RESULT;
                    end
                    else
                    begin
                        need_next     = need_calc;
                        scan_pos_next = pos0;
                        in_run_next   = 1'b0;
                        run_len_next  = '0;
                        wrapped_next  = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_FREE:
            begin
                if (rem_reg == '0 || ptr_reg >= PTR_MAX)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = 1'b0;
                    if (fc_reg != nfpa_pkg::COUNT_MAX)
                    begin
                        fc_next = fc_reg + nfpa_pkg::FREE_W'(1);
                    end
                    ptr_next = ptr_reg + PTR_W'(1);
                    rem_next = rem_reg - RM_W'(1);
                end
            end

            ST_SCAN:
            begin
                if (!in_run_reg)
                begin
                    if (!ram_rdata)
                    begin
                        run_start_next = scan_pos_reg;
                        run_len_next   = NEED_W'(1);
                        in_run_next    = 1'b1;
                    end
                end
                else if (ram_rdata)
                begin
                    in_run_next  = 1'b0;
                    run_len_next = '0;
                end
                else
                begin
                    run_len_next = run_len_reg + NEED_W'(1);
                end

                run_hit = in_run_next && (run_len_next == need_reg);

                if (run_hit)
                begin
                    cursor_next = nxt_pos;
                    fc_next     = (fc_ext >= need_ext) ?
                                  nfpa_pkg::FREE_W'(fc_ext - need_ext) : '0;
                    start_next  = run_start_next;
                    ptr_next    = PTR_W'(run_start_next);
                    rem_next    = need_ext;
                    state_next  = ST_TAKE;
                end
                else if (at_end && wrapped_reg)
                begin
                    ok_next     = 1'b0;
                    cursor_next = '0;
                    state_next  = ST_RESULT;
                end
                else
                begin
                    scan_pos_next = nxt_pos;
                    if (at_end)
                    begin
                        wrapped_next = 1'b1;
                        in_run_next  = 1'b0;
                        run_len_next = '0;
                    end
                end
            end

            ST_TAKE:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    ram_we   = 1'b1;
                    ptr_next = ptr_reg + PTR_W'(1);
                    rem_next = rem_reg - RM_W'(1);
                end
            end

            ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            ptr_reg    <= '0;
            cursor_reg <= '0;
            fc_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            cursor_reg <= cursor_next;
            fc_reg     <= fc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        need_reg      <= need_next;
        scan_pos_reg  <= scan_pos_next;
        run_start_reg <= run_start_next;
        run_len_reg   <= run_len_next;
        in_run_reg    <= in_run_next;
        wrapped_reg   <= wrapped_next;
        ok_reg        <= ok_next;
        mode_reg      <= mode_next;
        start_reg     <= start_next;
    end

    always_comb
    begin
        res.ok         = ok_reg;
        res.start_page = nfpa_pkg::START_W'(start_reg);
        res.free_pages = fc_reg;
        res.address    = (ok_reg && mode_reg == nfpa_pkg::MODE_ALLOC) ?
                         base_address + (nfpa_pkg::ADDR_W'(start_reg) << PBL) : '0;
    end

    a_no_write_in_scan: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !ram_we
    ) else $error("bitmap written during scan");

    a_run_below_need: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (run_len_reg < need_reg)
    ) else $error("run length passed request");

    a_fail_resets_cursor: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && !ok_reg) |-> (cursor_reg == '0)
    ) else $error("failed allocation left cursor set");

endmodule

`default_nettype wire

/* rtl/next_fit_page_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Next-fit page allocator over a one-bit-per-page taken map held in a single
// synchronous RAM. After reset a clearing pass marks every page taken;
// s_axis_tready stays low until it ends. One word is worked at a time, one map
// bit per cycle. A free-range word clears its pages; pages past the map are not
// visited. An allocation scans at most two passes over total_pages; a hit marks
// the run taken, while a miss or a zero-byte request returns ok low. A finished
// result sits in the output register, so the next word is taken while it waits.
// PAGE_BYTES must be a power of two.
module next_fit_page_allocator #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // mode, first_page, page_count, request_bytes
    input  wire logic [nfpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // ok, start_page, address, free_pages
    output logic      [nfpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [nfpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [nfpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int TOT_W = $clog2(MAX_PAGES) + 1;
    localparam int CMP_W = (TOT_W > nfpa_pkg::TOTAL_W) ? TOT_W : nfpa_pkg::TOTAL_W;
    localparam int RES_W = $bits(nfpa_pkg::nfpa_result_t);

    logic [nfpa_pkg::TOTAL_W-1:0] total_pages_reg;
    logic [nfpa_pkg::ADDR_W-1:0]  base_address_reg;
    logic [TOT_W-1:0]             total_used;

    logic                   out_vld_reg;
    logic [RES_W-1:0]       out_data_reg;
    nfpa_pkg::nfpa_item_t   item;
    nfpa_pkg::nfpa_result_t res;
    logic                   res_valid;
    logic                   res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_pages_reg  <= nfpa_pkg::TOTAL_DEFAULT;
            base_address_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nfpa_pkg::CFG_TOTAL_PAGES:
                begin
                    total_pages_reg <= cfg_data[nfpa_pkg::TOTAL_W-1:0];
                end
                nfpa_pkg::CFG_BASE_ADDRESS:
                begin
                    base_address_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (total_pages_reg == '0)
        begin
            total_used = TOT_W'(1);
        end
        else if (CMP_W'(total_pages_reg) > CMP_W'(MAX_PAGES))
        begin
            total_used = TOT_W'(MAX_PAGES);
        end
        else
        begin
            total_used = TOT_W'(total_pages_reg);
        end
    end

    assign item = nfpa_pkg::nfpa_item_t'(s_axis_tdata[$bits(nfpa_pkg::nfpa_item_t)-1:0]);

    nfpa_ctrl #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (s_axis_tvalid),
        .item_ready   (s_axis_tready),
        .item         (item),
        .total_used   (total_used),
        .base_address (base_address_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    assign res_ready = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_vld_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(nfpa_pkg::OUT_TDATA_W - RES_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

/* sim/tb_next_fit_page_allocator.sv */
`timescale 1ns / 1ps

module tb_next_fit_page_allocator;

    localparam int MAX_PAGES  = 4096;
    localparam int PAGE_BYTES = 4096;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int WORDS_PER_PHASE = 30;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        nfpa_pkg::nfpa_item_t            w;
        logic [nfpa_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [nfpa_pkg::CFG_DATA_W-1:0] reg_val;
        logic                            typed;
        nfpa_pkg::nfpa_result_t          res;
    } dir_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [nfpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [nfpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             cfg_we = 1'b0;
    logic [nfpa_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [nfpa_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // allocator shadow
    bit                             taken_map [MAX_PAGES];
    int                             scan_cursor;
    int                             free_tally;
    logic [nfpa_pkg::TOTAL_W-1:0]   total_reg;
    logic [nfpa_pkg::ADDR_W-1:0]    base_reg;

    nfpa_pkg::nfpa_result_t         pending_results [$];
    dir_row_t                       stim_table [$];
    nfpa_pkg::nfpa_result_t         got;
    nfpa_pkg::nfpa_result_t         want;
    int                             errors = 0;
    int                             cycle_count = 0;
    int                             src_idle_pct = 0;
    int                             sink_stall_pct = 0;

    int                             phase_total [4] = '{64, 200, 4096, 13};
    int                             phase_src [4]   = '{0, 53, 0, 7};
    int                             phase_sink [4]  = '{0, 0, 53, 7};
    logic [nfpa_pkg::ADDR_W-1:0]    phase_base;

    next_fit_page_allocator #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic nfpa_pkg::nfpa_result_t allocator_result(nfpa_pkg::nfpa_item_t w);
        nfpa_pkg::nfpa_result_t r;
        int need;
        int total;
        int pos;
        int run_start;
        int run_len;
        bit in_run;
        bit wrapped;
        bit found;
        bit done;
        r = '0;
        r.ok = 1'b1;
        if (w.mode == nfpa_pkg::MODE_FREE)
        begin
            for (int k = 0; k < int'(w.page_count); k++)
            begin
                if (int'(w.first_page) + k >= MAX_PAGES)
                    break;
                taken_map[int'(w.first_page) + k] = 1'b0;
                if (free_tally < int'(nfpa_pkg::COUNT_MAX))
                    free_tally++;
            end
        end
        else
        begin
            need = (int'(w.request_bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
            total = (total_reg == 0) ? 1 :
                    (total_reg > MAX_PAGES) ? MAX_PAGES : int'(total_reg);
            found = 1'b0;
            if (need != 0)
            begin
                pos = (scan_cursor >= total) ? 0 : scan_cursor;
                in_run = 1'b0;
                wrapped = 1'b0;
                run_start = 0;
                run_len = 0;
                done = 1'b0;
                while (!done)
                begin
                    if (!in_run)
                    begin
                        if (!taken_map[pos])
                        begin
                            run_start = pos;
                            run_len = 1;
                            in_run = 1'b1;
                        end
                    end
                    else if (taken_map[pos])
                    begin
                        in_run = 1'b0;
                        run_len = 0;
                    end
                    else
                        run_len++;

                    if (in_run && run_len == need)
                    begin
                        found = 1'b1;
                        done = 1'b1;
                        pos++;
                        if (pos >= total)
                            pos = 0;
                        scan_cursor = pos;
                    end
                    else
                    begin
                        pos++;
                        if (pos >= total)
                        begin
                            pos = 0;
                            if (wrapped)
                                done = 1'b1;
                            wrapped = 1'b1;
                            in_run = 1'b0;
                            run_len = 0;
                        end
                    end
                end
            end
            if (found)
            begin
                for (int k = 0; k < need; k++)
                    taken_map[run_start + k] = 1'b1;
                free_tally = (free_tally >= need) ? free_tally - need : 0;
                r.start_page = nfpa_pkg::START_W'(run_start);
                r.address = base_reg + nfpa_pkg::ADDR_W'(run_start) * PAGE_BYTES;
            end
            else
            begin
                scan_cursor = 0;
                r.ok = 1'b0;
            end
        end
        r.free_pages = nfpa_pkg::FREE_W'(free_tally);
        return r;
    endfunction

    function automatic nfpa_pkg::nfpa_item_t free_word(int first, int count);
        nfpa_pkg::nfpa_item_t w;
        w = '0;
        w.mode = nfpa_pkg::MODE_FREE;
        w.first_page = nfpa_pkg::FIRST_W'(first);
        w.page_count = nfpa_pkg::COUNT_W'(count);
        return w;
    endfunction

    function automatic nfpa_pkg::nfpa_item_t alloc_word(int bytes);
        nfpa_pkg::nfpa_item_t w;
        w = '0;
        w.mode = nfpa_pkg::MODE_ALLOC;
        w.request_bytes = nfpa_pkg::REQ_W'(bytes);
        return w;
    endfunction

    function automatic dir_row_t word_row(nfpa_pkg::nfpa_item_t w);
        dir_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.w = w;
        return r;
    endfunction

    function automatic dir_row_t typed_row(nfpa_pkg::nfpa_item_t w, logic ok, int free_pages);
        dir_row_t r;
        r = word_row(w);
        r.typed = 1'b1;
        r.res.ok = ok;
        r.res.free_pages = nfpa_pkg::FREE_W'(free_pages);
        return r;
    endfunction

    function automatic dir_row_t cfg_row(logic [nfpa_pkg::CFG_IDX_W-1:0] idx,
                                         logic [nfpa_pkg::CFG_DATA_W-1:0] val);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // mostly small runs inside the scanned window, now and then wider random ones
    function automatic nfpa_pkg::nfpa_item_t random_word(int total);
        nfpa_pkg::nfpa_item_t w;
        w.first_page = nfpa_pkg::FIRST_W'($urandom);
        w.page_count = nfpa_pkg::COUNT_W'($urandom_range(0, MAX_PAGES));
        w.request_bytes = nfpa_pkg::REQ_W'($urandom_range(0, 16777216));
        if ($urandom_range(0, 99) < 40)
        begin
            w.mode = nfpa_pkg::MODE_FREE;
            if ($urandom_range(0, 15) != 0)
            begin
                w.first_page = nfpa_pkg::FIRST_W'($urandom_range(0, total - 1));
                w.page_count = nfpa_pkg::COUNT_W'($urandom_range(0, 12));
            end
        end
        else
        begin
            w.mode = nfpa_pkg::MODE_ALLOC;
            if ($urandom_range(0, 15) != 0)
                w.request_bytes = nfpa_pkg::REQ_W'($urandom_range(0, 6 * PAGE_BYTES));
        end
        return w;
    endfunction

    task automatic send_word(input nfpa_pkg::nfpa_item_t w, input logic typed,
                             input nfpa_pkg::nfpa_result_t res);
        nfpa_pkg::nfpa_result_t pred;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(nfpa_pkg::IN_TDATA_W - $bits(nfpa_pkg::nfpa_item_t)){1'b0}}, w};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = allocator_result(w);
        pending_results.push_back(typed ? res : pred);
    endtask

    task automatic write_reg(input logic [nfpa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nfpa_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == nfpa_pkg::CFG_TOTAL_PAGES)
            total_reg = val[nfpa_pkg::TOTAL_W-1:0];
        else
            base_reg = val;
    endtask

    task automatic report_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = nfpa_pkg::nfpa_result_t'(m_axis_tdata[$bits(nfpa_pkg::nfpa_result_t)-1:0]);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual %0h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                report_field("ok", 64'(want.ok), 64'(got.ok));
                report_field("start_page", 64'(want.start_page), 64'(got.start_page));
                report_field("address", want.address, got.address);
                report_field("free_pages", 64'(want.free_pages), 64'(got.free_pages));
            end
        end
    end

    initial
    begin
        foreach (taken_map[i])
            taken_map[i] = 1'b1;
        scan_cursor = 0;
        free_tally = 0;
        total_reg = nfpa_pkg::TOTAL_DEFAULT;
        base_reg = '0;

        stim_table.push_back(typed_row(alloc_word(1), 1'b0, 0));
        stim_table.push_back(typed_row(alloc_word(0), 1'b0, 0));
        stim_table.push_back(typed_row(free_word(4095, 0), 1'b1, 0));
        stim_table.push_back(typed_row(free_word(4090, 10), 1'b1, 6));
        stim_table.push_back(typed_row(free_word(4095, 1), 1'b1, 7));
        stim_table.push_back(word_row(alloc_word(6 * PAGE_BYTES)));
        stim_table.push_back(word_row(free_word(0, 4096)));
        stim_table.push_back(typed_row(free_word(0, 4096), 1'b1, int'(nfpa_pkg::COUNT_MAX)));
        stim_table.push_back(word_row(alloc_word(16777216)));
        stim_table.push_back(word_row(free_word(100, 50)));
        stim_table.push_back(word_row(alloc_word(PAGE_BYTES + 1)));
        stim_table.push_back(cfg_row(nfpa_pkg::CFG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_F000));
        stim_table.push_back(word_row(alloc_word(PAGE_BYTES)));
        stim_table.push_back(cfg_row(nfpa_pkg::CFG_TOTAL_PAGES, 64'd64));
        stim_table.push_back(word_row(free_word(0, 8)));
        stim_table.push_back(word_row(alloc_word(2 * PAGE_BYTES)));
        stim_table.push_back(word_row(alloc_word(16777216)));
        stim_table.push_back(cfg_row(nfpa_pkg::CFG_TOTAL_PAGES, 64'd0));
        stim_table.push_back(word_row(alloc_word(1)));
        stim_table.push_back(word_row(free_word(0, 1)));
        stim_table.push_back(word_row(alloc_word(PAGE_BYTES - 1)));
        stim_table.push_back(cfg_row(nfpa_pkg::CFG_TOTAL_PAGES, 64'h1FFF));
        stim_table.push_back(cfg_row(nfpa_pkg::CFG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF));
        stim_table.push_back(word_row(alloc_word(1)));
        stim_table.push_back(word_row(free_word(12'hAAA, 13'h0555)));
        stim_table.push_back(word_row(alloc_word(25'h0AAAAAA)));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_CFG)
                write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
            else
                send_word(stim_table[i].w, stim_table[i].typed, stim_table[i].res);
        end

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: phase_base = 64'h0000_0000_0000_1000;
                1: phase_base = {$urandom, $urandom};
                2: phase_base = 64'hFFFF_FFFF_FFFF_FFFF;
                default: phase_base = '0;
            endcase
            write_reg(nfpa_pkg::CFG_TOTAL_PAGES, nfpa_pkg::CFG_DATA_W'(phase_total[p]));
            write_reg(nfpa_pkg::CFG_BASE_ADDRESS, phase_base);
            src_idle_pct = phase_src[p];
            sink_stall_pct = phase_sink[p];
            repeat (WORDS_PER_PHASE)
                send_word(random_word(phase_total[p]), 1'b0, '0);
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/nfpa_pkg.sv
rtl/nfpa_ram.sv
rtl/nfpa_ctrl.sv
rtl/next_fit_page_allocator.sv
sim/tb_next_fit_page_allocator.sv
